### sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the RTL in this folder.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### sv/zsmt_pkg.sv
// ---------------------------------------------------------------------------
// zsmt_pkg
// Types, codes and the control store of the zener sweep median tester.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package zsmt_pkg;

	// verdict / phase codes
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_TEST = 2'd1;
	localparam logic [1:0] PH_PASS = 2'd2;
	localparam logic [1:0] PH_FAIL = 2'd3;

	// configuration register indexes
	localparam logic REG_MEDIAN_LIMIT = 1'b0;
	localparam logic REG_STEP_MV      = 1'b1;

	localparam logic [11:0] LIMIT_RESET = 12'd4030;
	localparam logic [8:0]  STEP_RESET  = 9'd50;
	localparam logic [11:0] CODE_MAX    = 12'd4095;

	// command codes
	localparam logic CMD_PRESS  = 1'b0;
	localparam logic CMD_SAMPLE = 1'b1;

	// sequencer step addresses
	typedef logic [3:0] step_t;
	localparam step_t S_WAIT   = 4'd0;
	localparam step_t S_EXEC   = 4'd1;
	localparam step_t S_LOADI  = 4'd2;
	localparam step_t S_CAPI   = 4'd3;
	localparam step_t S_RDJ    = 4'd4;
	localparam step_t S_CMPJ   = 4'd5;
	localparam step_t S_CHKI   = 4'd6;
	localparam step_t S_DECIDE = 4'd7;
	localparam step_t S_MUL    = 4'd8;
	localparam step_t S_SAT    = 4'd9;
	localparam step_t S_EMIT   = 4'd10;

	// datapath operations
	typedef enum logic [3:0] {
		OP_NOP,
		OP_EXEC,
		OP_RD_I,
		OP_CAP_I,
		OP_RD_J,
		OP_CMP_J,
		OP_CHK_I,
		OP_DECIDE,
		OP_MUL,
		OP_SAT,
		OP_EMIT
	} op_t;

	// jump conditions
	typedef enum logic [2:0] {
		C_NONE,
		C_ACCEPT,
		C_NO_GROUP,
		C_J_MORE,
		C_NOT_FOUND,
		C_NO_RISE,
		C_OUT_FREE
	} cond_t;

	// one control word: jump to target when cond holds, else hold or advance
	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  stay;
		step_t target;
	} ctl_t;

	// control store
	function automatic ctl_t ucode_rom(input step_t step);
		ctl_t w;
		unique case (step)
			S_WAIT:   w = '{op: OP_NOP,    cond: C_ACCEPT,    stay: 1'b1, target: S_EXEC};
			S_EXEC:   w = '{op: OP_EXEC,   cond: C_NO_GROUP,  stay: 1'b0, target: S_EMIT};
			S_LOADI:  w = '{op: OP_RD_I,   cond: C_NONE,      stay: 1'b0, target: S_WAIT};
			S_CAPI:   w = '{op: OP_CAP_I,  cond: C_NONE,      stay: 1'b0, target: S_WAIT};
			S_RDJ:    w = '{op: OP_RD_J,   cond: C_NONE,      stay: 1'b0, target: S_WAIT};
			S_CMPJ:   w = '{op: OP_CMP_J,  cond: C_J_MORE,    stay: 1'b0, target: S_RDJ};
			S_CHKI:   w = '{op: OP_CHK_I,  cond: C_NOT_FOUND, stay: 1'b0, target: S_LOADI};
			S_DECIDE: w = '{op: OP_DECIDE, cond: C_NO_RISE,   stay: 1'b0, target: S_EMIT};
			S_MUL:    w = '{op: OP_MUL,    cond: C_NONE,      stay: 1'b0, target: S_WAIT};
			S_SAT:    w = '{op: OP_SAT,    cond: C_NONE,      stay: 1'b0, target: S_WAIT};
			S_EMIT:   w = '{op: OP_EMIT,   cond: C_OUT_FREE,  stay: 1'b1, target: S_WAIT};
			default:  w = '{op: OP_NOP,    cond: C_NONE,      stay: 1'b0, target: S_WAIT};
		endcase
		return w;
	endfunction

endpackage

### sv/zsmt_ram.sv
// ---------------------------------------------------------------------------
// zsmt_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module zsmt_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 10
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### sv/zener_sweep_median_tester_unit.sv
// ---------------------------------------------------------------------------
// zener_sweep_median_tester_unit
// Zener diode voltage sweep tester with per-level median filtering.
// ---------------------------------------------------------------------------
// A press while idle starts a sweep from 0 mV and asks for a conversion;
// each level gathers SAMPLES_PER_LEVEL samples, the sample of rank
// MEDIAN_RANK is the level's median, a median below median_limit moves the
// level up by step_millivolts until REF_MILLIVOLTS (pass), otherwise fail.
// A press while busy returns to idle. Every input transaction yields one
// result transaction. A small microcoded sequencer runs the block, one
// transaction at a time: a press, an ignored sample or a sample inside a
// group passes through the exec and emit steps, and emit holds until the
// result register is free. A sample that closes a group runs a rank search
// over the sample RAM through its single read port, for each of up to
// SAMPLES_PER_LEVEL candidates a load, a capture, a read and compare of
// every sample and a check, then a decide step, and when the level moves a
// DAC code recompute (a multiply by the reciprocal of REF_MILLIVOLTS, then
// a saturate), before the result is emitted.
// No clearing pass after reset; configuration writes take effect at once.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module zener_sweep_median_tester_unit
	import zsmt_pkg::*;
#(
	parameter int SAMPLES_PER_LEVEL = 10,
	parameter int MEDIAN_RANK       = 4,
	parameter int REF_MILLIVOLTS    = 2500,
	parameter int DAC_FULL_SCALE    = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [11:0] adc_sample,
	// result channel
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] dac_code,
	output logic        start_conversion,
	output logic [1:0]  verdict,
	output logic [11:0] sweep_step,
	output logic [11:0] median_value,
	output logic        group_done,
	// configuration
	input  logic        cfg_we,
	input  logic        cfg_idx,
	input  logic [11:0] cfg_wdata
);

	localparam int N       = SAMPLES_PER_LEVEL;
	localparam int AW      = $clog2(N);
	localparam int RANK    = (MEDIAN_RANK > N - 1) ? N - 1 : MEDIAN_RANK;
	// level*DAC_FULL_SCALE/REF_MILLIVOLTS as level*RECIP >> RK, exact for
	// every 12-bit level
	localparam int RK      = 12 + $clog2(REF_MILLIVOLTS);
	localparam int MW      = $clog2(DAC_FULL_SCALE) + 16;
	localparam int PRW     = 12 + MW;
	localparam int QW      = PRW - RK;

	localparam logic [63:0] RECIP = ((64'(DAC_FULL_SCALE) << RK) +
		64'(REF_MILLIVOLTS - 1)) / 64'(REF_MILLIVOLTS);

	localparam logic [AW-1:0] LAST_IDX  = AW'(N - 1);
	localparam logic [AW-1:0] RANK_IDX  = AW'(RANK);
	localparam logic [11:0]   REF_LVL   = 12'(REF_MILLIVOLTS);
	localparam logic [MW-1:0] RECIP_C   = RECIP[MW-1:0];
	localparam logic [QW-1:0] DAC_MAX_Q = QW'(CODE_MAX);

	// sequencer
	step_t step_q;
	step_t step_nxt;
	ctl_t  ctl;
	logic  cond_hit;

	// configuration registers
	logic [11:0] limit_q;
	logic [8:0]  step_mv_q;

	// architectural state
	logic [AW-1:0] count_q;
	logic [11:0]   level_q;
	logic [11:0]   index_q;
	logic [1:0]    phase_q;
	logic [11:0]   median_q;
	logic [11:0]   dac_q;
	logic          start_q;
	logic          done_q;

	// latched transaction
	logic          cmd_q;
	logic [11:0]   smp_q;

	// rank search datapath
	logic [AW-1:0] i_q;
	logic [AW-1:0] j_q;
	logic [AW-1:0] cnt_q;
	logic [11:0]   cand_q;
	logic [11:0]   ram_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_raddr;
	logic          ranks_below;

	// DAC code datapath
	logic [PRW-1:0]  prod_q;
	logic [QW-1:0]   quot;

	// result register
	logic            out_valid_q;
	logic            out_free;
	logic [11:0]     out_dac_q;
	logic            out_start_q;
	logic [1:0]      out_verdict_q;
	logic [11:0]     out_step_q;
	logic [11:0]     out_median_q;
	logic            out_done_q;

	logic group_end;
	logic rise;
	logic accept;

	assign ctl       = ucode_rom(step_q);
	assign in_ready  = (step_q == S_WAIT);
	assign accept    = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;

	// a sample during test that fills the group
	assign group_end = (cmd_q == CMD_SAMPLE) && (phase_q == PH_TEST) && (count_q == LAST_IDX);
	assign rise      = (median_q < limit_q) && (level_q < REF_LVL);

	// stable-order rank contribution of sample j against the candidate
	assign ranks_below = (ram_rdata < cand_q) || ((ram_rdata == cand_q) && (j_q < i_q));

	// quotient of the reciprocal product
	assign quot = prod_q[PRW-1:RK];

	// jump condition select
	always_comb begin
		case (ctl.cond)
			C_NONE:      cond_hit = 1'b0;
			C_ACCEPT:    cond_hit = in_valid;
			C_NO_GROUP:  cond_hit = !group_end;
			C_J_MORE:    cond_hit = (j_q != LAST_IDX);
			C_NOT_FOUND: cond_hit = (cnt_q != RANK_IDX);
			C_NO_RISE:   cond_hit = !rise;
			C_OUT_FREE:  cond_hit = out_free;
			default:     cond_hit = 1'b0;
		endcase
	end

	// next step
	always_comb begin
		if (cond_hit) begin
			step_nxt = ctl.target;
		end else if (ctl.stay) begin
			step_nxt = step_q;
		end else begin
			step_nxt = step_q + step_t'(1);
		end
	end

	// sample store
	assign ram_we    = (ctl.op == OP_EXEC) && (cmd_q == CMD_SAMPLE) && (phase_q == PH_TEST);
	assign ram_raddr = (ctl.op == OP_RD_I) ? i_q : j_q;

	zsmt_ram #(
		.WIDTH(12),
		.DEPTH(N)
	) u_samples (
		.clk   (clk),
		.we    (ram_we),
		.waddr (count_q),
		.wdata (smp_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// control and architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= S_WAIT;
			limit_q     <= LIMIT_RESET;
			step_mv_q   <= STEP_RESET;
			count_q     <= '0;
			level_q     <= '0;
			index_q     <= '0;
			phase_q     <= PH_IDLE;
			median_q    <= '0;
			dac_q       <= '0;
			start_q     <= 1'b0;
			done_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			step_q <= step_nxt;

			if (cfg_we) begin
				unique case (cfg_idx)
					REG_MEDIAN_LIMIT: limit_q   <= cfg_wdata;
					REG_STEP_MV:      step_mv_q <= cfg_wdata[8:0];
				endcase
			end

			// result valid: set on emit, cleared when taken
			if ((ctl.op == OP_EMIT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (ctl.op)
				OP_EXEC: begin
					done_q <= 1'b0;
					if (cmd_q == CMD_PRESS) begin
						if (phase_q == PH_IDLE) begin
							count_q <= '0;
							index_q <= '0;
							level_q <= '0;
							dac_q   <= '0;
							phase_q <= PH_TEST;
							start_q <= 1'b1;
						end else begin
							phase_q <= PH_IDLE;
							start_q <= 1'b0;
						end
					end else if (phase_q == PH_TEST) begin
						if (count_q == LAST_IDX) begin
							count_q <= '0;
							start_q <= 1'b0;
						end else begin
							count_q <= count_q + AW'(1);
							start_q <= 1'b1;
						end
					end else begin
						start_q <= 1'b0;
					end
				end
				OP_CHK_I: begin
					if (cnt_q == RANK_IDX) begin
						median_q <= cand_q;
					end
				end
				OP_DECIDE: begin
					done_q <= 1'b1;
					if (median_q < limit_q) begin
						if (level_q < REF_LVL) begin
							if (index_q != CODE_MAX) begin
								index_q <= index_q + 12'd1;
							end
							level_q <= level_q + {3'd0, step_mv_q};
							start_q <= 1'b1;
						end else begin
							phase_q <= PH_PASS;
						end
					end else begin
						phase_q <= PH_FAIL;
					end
				end
				OP_SAT: begin
					dac_q <= (quot > DAC_MAX_Q) ? CODE_MAX : quot[11:0];
				end
				OP_NOP, OP_RD_I, OP_CAP_I, OP_RD_J, OP_CMP_J, OP_MUL, OP_EMIT: begin
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= command;
			smp_q <= adc_sample;
		end
		case (ctl.op)
			OP_EXEC: begin
				i_q <= '0;
			end
			OP_CAP_I: begin
				cand_q <= ram_rdata;
				cnt_q  <= '0;
				j_q    <= '0;
			end
			OP_CMP_J: begin
				if (ranks_below) begin
					cnt_q <= cnt_q + AW'(1);
				end
				j_q <= j_q + AW'(1);
			end
			OP_CHK_I: begin
				i_q <= i_q + AW'(1);
			end
			OP_MUL: begin
				prod_q <= PRW'(level_q) * PRW'(RECIP_C);
			end
			OP_EMIT: begin
				if (out_free) begin
					out_dac_q     <= dac_q;
					out_start_q   <= start_q;
					out_verdict_q <= phase_q;
					out_step_q    <= index_q;
					out_median_q  <= median_q;
					out_done_q    <= done_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign out_valid        = out_valid_q;
	assign dac_code         = out_dac_q;
	assign start_conversion = out_start_q;
	assign verdict          = out_verdict_q;
	assign sweep_step       = out_step_q;
	assign median_value     = out_median_q;
	assign group_done       = out_done_q;

	// checks
	`ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, step_q == S_EXEC, "accept did not enter exec")
	`ASSERT_IMPLIES(a_done_phase, clk, arst_n, out_valid && group_done, verdict != PH_IDLE, "group done while idle")
	`ASSERT_IMPLIES(a_start_test, clk, arst_n, out_valid && start_conversion, verdict == PH_TEST, "conversion request outside test")
	`ASSERT_NEXT(a_sat_emit, clk, arst_n, step_q == S_SAT, step_q == S_EMIT, "saturate not followed by emit")

endmodule
